/* rtl/izrk_pkg.sv */
// ----------------------------------------------------------------------------
// izrk_pkg
// Types, constants and helpers shared by the Izhikevich RK4 integrator.
// ----------------------------------------------------------------------------
package izrk_pkg;

  localparam int VAL_W     = 48;
  localparam int ACC_W     = 54;
  localparam int DQ_W      = ACC_W - 1;
  localparam int Q32_W     = 32;
  localparam int TIME_W    = 64;
  localparam int IDX_W     = 3;
  localparam int FRAC_BITS = 32;
  localparam int MAX_HALVINGS = 32;
  localparam int HALV_W    = 6;
  localparam int DCNT_W    = 6;
  // first divide step that only corrects the quotient
  localparam int DIV_FIX_STEP = 7;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  // round(0.04 * 2^FRAC_BITS)
  localparam val_t C004    = val_t'(((64'sd4 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
  localparam acc_t C140    = acc_t'(64'sd140 <<< FRAC_BITS);
  localparam val_t THIRTY  = val_t'(64'sd30 <<< FRAC_BITS);

  typedef enum logic [2:0] {
    REG_CURRENT   = 3'd0,
    REG_RATE      = 3'd1,
    REG_SENS      = 3'd2,
    REG_RESET_POT = 3'd3,
    REG_RESET_INC = 3'd4,
    REG_STEP      = 3'd5,
    REG_TOL       = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SPIKE, ST_TRIAL,
    ST_M_VV, ST_W_VV, ST_M_Q, ST_W_Q,
    ST_ADD_V4, ST_ADD_V, ST_ADD_C, ST_SUB_U, ST_ADD_I, ST_SAT_DV,
    ST_M_BV, ST_W_BV, ST_SUB_U2, ST_M_AX, ST_W_AX,
    ST_M_HV, ST_W_HV, ST_M_HU, ST_W_HU,
    ST_STAGE, ST_DIV, ST_FIN, ST_CHECK, ST_HALVE, ST_DONE
  } state_t;

  function automatic val_t sat48(input acc_t x);
    if (x > acc_t'(VAL_MAX)) return VAL_MAX;
    if (x < acc_t'(VAL_MIN)) return VAL_MIN;
    return x[VAL_W-1:0];
  endfunction

  // halve, truncating toward zero
  function automatic acc_t half0(input val_t k);
    acc_t t;
    t = acc_t'(k) + acc_t'({1'b0, k[VAL_W-1]});
    return t >>> 1;
  endfunction

endpackage

/* rtl/izrk_in_if.sv */
// ----------------------------------------------------------------------------
// izrk_in_if
// Input item channel: load or tick items.
// ----------------------------------------------------------------------------
interface izrk_in_if import izrk_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  val_t init_v;
  val_t init_u;
  modport source (output valid, kind, init_v, init_u, input ready);
  modport sink   (input valid, kind, init_v, init_u, output ready);
endinterface

/* rtl/izrk_out_if.sv */
// ----------------------------------------------------------------------------
// izrk_out_if
// Result item channel: neuron state, time and step information.
// ----------------------------------------------------------------------------
interface izrk_out_if import izrk_pkg::*; ();
  logic              valid;
  logic              ready;
  val_t              membrane_out;
  val_t              recovery_out;
  logic [TIME_W-1:0] time_out;
  logic              event_located;
  logic [Q32_W-1:0]  step_used;
  modport source (output valid, membrane_out, recovery_out, time_out, event_located,
                  step_used, input ready);
  modport sink   (input valid, membrane_out, recovery_out, time_out, event_located,
                  step_used, output ready);
endinterface

/* rtl/izrk_cfg_if.sv */
// ----------------------------------------------------------------------------
// izrk_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface izrk_cfg_if import izrk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  val_t             data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/izrk_mul.sv */
// ----------------------------------------------------------------------------
// izrk_mul
// Signed fixed point multiply, four 24x24 partial products accumulated in turn,
// rounded half away from zero and saturated to 48 bits.
// ----------------------------------------------------------------------------
module izrk_mul import izrk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  val_t a,
  input  val_t b,
  output logic done,
  output val_t p
);

  localparam int HW = VAL_W / 2;
  localparam int PW = 2 * VAL_W;

  logic              busy;
  logic [2:0]        cnt;
  logic              neg;
  logic [VAL_W-1:0]  ma;
  logic [VAL_W-1:0]  mb;
  logic [PW-1:0]     prod;
  logic [HW-1:0]     x;
  logic [HW-1:0]     y;
  logic [VAL_W-1:0]  part;
  logic [PW-1:0]     part_sh;
  logic [PW:0]       rnd;
  logic [63:0]       mag;

  always_comb begin
    x = cnt[1] ? ma[VAL_W-1:HW] : ma[HW-1:0];
    y = cnt[0] ? mb[VAL_W-1:HW] : mb[HW-1:0];
    part = VAL_W'(x) * VAL_W'(y);
    case (cnt[1:0])
      2'd0:    part_sh = PW'(part);
      2'd3:    part_sh = PW'(part) << VAL_W;
      default: part_sh = PW'(part) << HW;
    endcase
    rnd = {1'b0, prod} + ((PW+1)'(1) << (FRAC_BITS - 1));
    mag = rnd[FRAC_BITS +: 64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        done <= 1'b0;
      end else if (busy && cnt == 3'd4) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
        if (busy) cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= a[VAL_W-1] ^ b[VAL_W-1];
      ma   <= a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
      mb   <= b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
      prod <= '0;
    end else if (busy) begin
      if (cnt == 3'd4) begin
        if (neg) begin
          if (mag > 64'(VAL_MIN[VAL_W-1:0])) p <= VAL_MIN;
          else                               p <= -val_t'(mag[VAL_W-1:0]);
        end else begin
          if (mag > 64'(VAL_MAX)) p <= VAL_MAX;
          else                    p <= val_t'(mag[VAL_W-1:0]);
        end
      end else begin
        prod <= prod + part_sh;
      end
    end
  end

endmodule

/* rtl/izhikevich_rk4_integrator_top.sv */
// ----------------------------------------------------------------------------
// izhikevich_rk4_integrator_top
// Izhikevich neuron with spike reset and classic RK4 steps, halving retries.
// ----------------------------------------------------------------------------
// A load item sets v and u and clears time; a tick item applies the spike
// reset, then runs RK4 trials on one shared multiplier (24 multiplies per
// trial) and divides the weighted sums by six with a shift-add reciprocal
// and a short correction loop. A tick takes one trial, or up to 33 trials
// when the step overshoots and is halved.
// Input ready is low while an item is in work; config writes are always taken.
module izhikevich_rk4_integrator_top import izrk_pkg::*; (
  input logic           clk,
  input logic           rst,
  izrk_in_if.sink       in_chan,
  izrk_out_if.source    out_chan,
  izrk_cfg_if.sink      cfg
);

  state_t state, state_next;

  val_t current, rate, sens, reset_pot, reset_inc;
  logic [Q32_W-1:0] step_size, tolerance;

  val_t membrane_v, recovery_u;
  logic [TIME_W-1:0] elapsed_time;

  val_t v0, u0, sv, su, dv, du, kv, ku, tmp, nv, nu;
  acc_t acc, sumv, sumu;
  logic [Q32_W-1:0] used;
  logic located;
  logic [HALV_W-1:0] halv;
  logic [1:0] stage;

  logic [ACC_W-2:0] dq_v, dq_u;
  logic [ACC_W-2:0] quo_v, quo_u, rem_v, rem_u;
  logic neg_v, neg_u;
  logic [DCNT_W-1:0] dcnt;

  logic mul_start, mul_done;
  val_t mul_a, mul_b, mul_p;

  val_t h_fx, limit;
  acc_t kv_w, ku_w, qv_s, qu_s;

  function automatic logic sumv_next_neg(input acc_t x);
    return x[ACC_W-1];
  endfunction

  function automatic logic [ACC_W-2:0] mag53(input acc_t x);
    acc_t m;
    m = x[ACC_W-1] ? -x : x;
    return m[ACC_W-2:0];
  endfunction

  izrk_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign cfg.ready     = 1'b1;
  assign in_chan.ready = (state == ST_IDLE);
  assign h_fx  = val_t'({1'b0, used});
  assign limit = THIRTY + val_t'({1'b0, tolerance});
  assign kv_w  = (stage == 2'd1 || stage == 2'd2) ? acc_t'(kv) <<< 1 : acc_t'(kv);
  assign ku_w  = (stage == 2'd1 || stage == 2'd2) ? acc_t'(ku) <<< 1 : acc_t'(ku);
  assign qv_s  = neg_v ? -acc_t'({1'b0, quo_v}) : acc_t'({1'b0, quo_v});
  assign qu_s  = neg_u ? -acc_t'({1'b0, quo_u}) : acc_t'({1'b0, quo_u});

  always_ff @(posedge clk) begin
    if (rst) begin
      current   <= '0;
      rate      <= val_t'(48'sd85899346);
      sens      <= val_t'(48'sd8589934592);
      reset_pot <= val_t'(-48'sd128849018880);
      reset_inc <= val_t'(48'sd17179869184);
      step_size <= 32'd4294967;
      tolerance <= 32'd42950;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CURRENT:   current   <= cfg.data;
        REG_RATE:      rate      <= cfg.data;
        REG_SENS:      sens      <= cfg.data;
        REG_RESET_POT: reset_pot <= cfg.data;
        REG_RESET_INC: reset_inc <= cfg.data;
        REG_STEP:      step_size <= cfg.data[Q32_W-1:0];
        REG_TOL:       tolerance <= cfg.data[Q32_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_chan.valid) state_next = in_chan.kind ? ST_SPIKE : ST_DONE;
      ST_SPIKE:  state_next = ST_TRIAL;
      ST_TRIAL:  state_next = ST_M_VV;
      ST_M_VV:   state_next = ST_W_VV;
      ST_W_VV:   if (mul_done) state_next = ST_M_Q;
      ST_M_Q:    state_next = ST_W_Q;
      ST_W_Q:    if (mul_done) state_next = ST_ADD_V4;
      ST_ADD_V4: state_next = ST_ADD_V;
      ST_ADD_V:  state_next = ST_ADD_C;
      ST_ADD_C:  state_next = ST_SUB_U;
      ST_SUB_U:  state_next = ST_ADD_I;
      ST_ADD_I:  state_next = ST_SAT_DV;
      ST_SAT_DV: state_next = ST_M_BV;
      ST_M_BV:   state_next = ST_W_BV;
      ST_W_BV:   if (mul_done) state_next = ST_SUB_U2;
      ST_SUB_U2: state_next = ST_M_AX;
      ST_M_AX:   state_next = ST_W_AX;
      ST_W_AX:   if (mul_done) state_next = ST_M_HV;
      ST_M_HV:   state_next = ST_W_HV;
      ST_W_HV:   if (mul_done) state_next = ST_M_HU;
      ST_M_HU:   state_next = ST_W_HU;
      ST_W_HU:   if (mul_done) state_next = ST_STAGE;
      ST_STAGE:  state_next = (stage == 2'd3) ? ST_DIV : ST_M_VV;
      ST_DIV: begin
        if (dcnt == DCNT_W'(DIV_FIX_STEP) && rem_v < DQ_W'(3) && rem_u < DQ_W'(3))
          state_next = ST_FIN;
      end
      ST_FIN:    state_next = ST_CHECK;
      ST_CHECK: begin
        if (halv == '0) state_next = (nv > THIRTY) ? ST_HALVE : ST_DONE;
        else if (nv < limit || halv == HALV_W'(MAX_HALVINGS)) state_next = ST_DONE;
        else state_next = ST_HALVE;
      end
      ST_HALVE:  state_next = ST_TRIAL;
      ST_DONE:   if (!out_chan.valid || out_chan.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = sv;
    mul_b     = sv;
    case (state)
      ST_M_VV: mul_start = 1'b1;
      ST_M_Q:  begin mul_start = 1'b1; mul_a = C004; mul_b = tmp; end
      ST_M_BV: begin mul_start = 1'b1; mul_a = sens; mul_b = sv;  end
      ST_M_AX: begin mul_start = 1'b1; mul_a = rate; mul_b = sat48(acc); end
      ST_M_HV: begin mul_start = 1'b1; mul_a = h_fx; mul_b = dv;  end
      ST_M_HU: begin mul_start = 1'b1; mul_a = h_fx; mul_b = du;  end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      membrane_v   <= '0;
      recovery_u   <= '0;
      elapsed_time <= '0;
      located      <= 1'b0;
      used         <= '0;
      halv         <= '0;
      stage        <= '0;
      dcnt         <= '0;
    end else begin
      case (state)
        ST_IDLE: if (in_chan.valid) begin
          located <= 1'b0;
          halv    <= '0;
          if (in_chan.kind) begin
            used <= step_size;
          end else begin
            used         <= '0;
            membrane_v   <= in_chan.init_v;
            recovery_u   <= in_chan.init_u;
            elapsed_time <= '0;
          end
        end
        ST_SPIKE: begin
          if (membrane_v > THIRTY) begin
            v0 <= reset_pot;
            u0 <= sat48(acc_t'(recovery_u) + acc_t'(reset_inc));
          end else begin
            v0 <= membrane_v;
            u0 <= recovery_u;
          end
        end
        ST_TRIAL: begin
          stage <= '0;
          sumv  <= '0;
          sumu  <= '0;
          sv    <= v0;
          su    <= u0;
        end
        ST_W_VV:   if (mul_done) tmp <= mul_p;
        ST_W_Q:    if (mul_done) acc <= acc_t'(mul_p);
        ST_ADD_V4: acc <= acc + (acc_t'(sv) <<< 2);
        ST_ADD_V:  acc <= acc + acc_t'(sv);
        ST_ADD_C:  acc <= acc + C140;
        ST_SUB_U:  acc <= acc - acc_t'(su);
        ST_ADD_I:  acc <= acc + acc_t'(current);
        ST_SAT_DV: dv  <= sat48(acc);
        ST_W_BV:   if (mul_done) acc <= acc_t'(mul_p);
        ST_SUB_U2: acc <= acc - acc_t'(su);
        ST_W_AX:   if (mul_done) du <= mul_p;
        ST_W_HV:   if (mul_done) kv <= mul_p;
        ST_W_HU:   if (mul_done) ku <= mul_p;
        ST_STAGE: begin
          sumv  <= sumv + kv_w;
          sumu  <= sumu + ku_w;
          stage <= stage + 2'd1;
          if (stage == 2'd2) begin
            sv <= sat48(acc_t'(v0) + acc_t'(kv));
            su <= sat48(acc_t'(u0) + acc_t'(ku));
          end else begin
            sv <= sat48(acc_t'(v0) + half0(kv));
            su <= sat48(acc_t'(u0) + half0(ku));
          end
          // load the divider with the magnitudes of the weighted sums
          neg_v <= sumv_next_neg(sumv + kv_w);
          neg_u <= sumv_next_neg(sumu + ku_w);
          dq_v  <= mag53(sumv + kv_w);
          dq_u  <= mag53(sumu + ku_w);
          rem_v <= '0;
          rem_u <= '0;
          dcnt  <= '0;
        end
        ST_DIV: begin
          // x / 6 = (x / 2) / 3; estimate below with 1/4 + 1/16 + ..., then correct
          if (dcnt < DCNT_W'(DIV_FIX_STEP)) dcnt <= dcnt + DCNT_W'(1);
          case (dcnt)
            DCNT_W'(0): begin
              quo_v <= (dq_v >> 3) + (dq_v >> 5);
              quo_u <= (dq_u >> 3) + (dq_u >> 5);
            end
            DCNT_W'(1): begin
              quo_v <= quo_v + (quo_v >> 4);
              quo_u <= quo_u + (quo_u >> 4);
            end
            DCNT_W'(2): begin
              quo_v <= quo_v + (quo_v >> 8);
              quo_u <= quo_u + (quo_u >> 8);
            end
            DCNT_W'(3): begin
              quo_v <= quo_v + (quo_v >> 16);
              quo_u <= quo_u + (quo_u >> 16);
            end
            DCNT_W'(4): begin
              quo_v <= quo_v + (quo_v >> 32);
              quo_u <= quo_u + (quo_u >> 32);
            end
            DCNT_W'(5): begin
              rem_v <= (dq_v >> 1) - quo_v;
              rem_u <= (dq_u >> 1) - quo_u;
            end
            DCNT_W'(6): begin
              rem_v <= rem_v - (quo_v << 1);
              rem_u <= rem_u - (quo_u << 1);
            end
            default: begin
              if (rem_v >= DQ_W'(3)) begin
                quo_v <= quo_v + DQ_W'(1);
                rem_v <= rem_v - DQ_W'(3);
              end
              if (rem_u >= DQ_W'(3)) begin
                quo_u <= quo_u + DQ_W'(1);
                rem_u <= rem_u - DQ_W'(3);
              end
            end
          endcase
        end
        ST_FIN: begin
          nv <= sat48(acc_t'(v0) + qv_s);
          nu <= sat48(acc_t'(u0) + qu_s);
        end
        ST_CHECK: begin
          if (state_next == ST_DONE) begin
            membrane_v   <= nv;
            recovery_u   <= nu;
            elapsed_time <= elapsed_time + TIME_W'(used);
          end else begin
            located <= 1'b1;
          end
        end
        ST_HALVE: begin
          used <= used >> 1;
          halv <= halv + HALV_W'(1);
        end
        default: ;
      endcase
    end
  end

  // result register; hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_chan.valid || out_chan.ready)) begin
        out_chan.valid         <= 1'b1;
        out_chan.membrane_out  <= membrane_v;
        out_chan.recovery_out  <= recovery_u;
        out_chan.time_out      <= elapsed_time;
        out_chan.event_located <= located;
        out_chan.step_used     <= used;
      end else if (out_chan.valid && out_chan.ready) begin
        out_chan.valid <= 1'b0;
      end
    end
  end

endmodule
